// ===== rtl/hes_pkg.sv =====
`default_nettype none

package hes_pkg;

    localparam int MAX_DATA_BITS = 57;
    localparam int MAX_CODE_BITS = 63;
    localparam int LEN_W         = 6;
    localparam int SYN_W         = 6;
    localparam int GROUP_BITS    = 16;
    localparam int NUM_GROUPS    = (MAX_CODE_BITS + GROUP_BITS - 1) / GROUP_BITS;

    localparam logic [LEN_W-1:0] DATA_LENGTH_RESET = LEN_W'(7);

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_CHECK  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic [MAX_DATA_BITS-1:0]   data_word;
        logic [MAX_CODE_BITS-1:0]   received_word;
    } in_item_t;

    typedef struct packed {
        logic [MAX_CODE_BITS-1:0]   code_word;
        logic [SYN_W-1:0]           error_position;
        logic                       error_found;
    } out_item_t;

    // Item between the masking stage and the syndrome stages
    typedef struct packed {
        opcode_t                    opcode;
        logic [MAX_CODE_BITS-1:0]   word;
    } prep_item_t;

    // Clamp the register value to 1..MAX_DATA_BITS
    function automatic logic [LEN_W-1:0] eff_data_bits(input logic [LEN_W-1:0] dl);
        logic [LEN_W-1:0] n;
        n = dl;
        if (n == '0) begin
            n = LEN_W'(1);
        end
        if (n > LEN_W'(MAX_DATA_BITS)) begin
            n = LEN_W'(MAX_DATA_BITS);
        end
        return n;
    endfunction

    // Codeword length: n plus the smallest r with 2^r >= n + r + 1
    function automatic logic [LEN_W-1:0] code_length(input logic [LEN_W-1:0] n);
        logic [2:0]       r;
        logic [LEN_W+1:0] lim;
        r = 3'd6;
        for (int k = 6; k >= 1; k--) begin
            lim = (LEN_W+2)'(n) + (LEN_W+2)'(k) + (LEN_W+2)'(1);
            if ((LEN_W+2)'(1 << k) >= lim) begin
                r = 3'(k);
            end
        end
        return n + LEN_W'(r);
    endfunction

    // Data bits, least significant first, to the non power of two positions
    function automatic logic [MAX_CODE_BITS-1:0] scatter(
        input logic [MAX_DATA_BITS-1:0] data
    );
        logic [MAX_CODE_BITS-1:0] w;
        int                       d;
        w = '0;
        d = 0;
        for (int p = 1; p <= MAX_CODE_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (d < MAX_DATA_BITS) begin
                    w[p-1] = data[d];
                end
                d++;
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hamming_encode_and_syndrome.sv =====
`default_nettype none

// Channel   | Handshake                   | Payload
// ----------+-----------------------------+------------------------------------------------
// command   | start (busy never high)     | cmd: opcode, data_word, received_word
// result    | done, one cycle, no stall   | result: code_word, error_position, error_found
// config    | cfg_valid / cfg_ready       | cfg_data: data_length (6 bits)
//
// One item per clock, every clock. Three register stages: mask and scatter,
// partial syndromes over four groups of up to sixteen positions, then the combine
// and result register; done comes from the third. rst_n is asynchronous and
// clears the valid bits and sets data_length to 7. The receiver cannot hold
// results off, so nothing ever stalls: busy and cfg_ready are constant.

module hamming_encode_and_syndrome
    import hes_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // command channel
    input  wire logic              start,
    output logic                   busy,
    input  wire in_item_t          cmd,

    // result channel
    output logic                   done,
    output out_item_t              result,

    // configuration channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [LEN_W-1:0]  cfg_data
);

    logic [LEN_W-1:0] data_length_reg;
    logic             accept;
    logic             prep_valid;
    prep_item_t       prep_item;

    // pipeline never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // data_length register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            data_length_reg <= DATA_LENGTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            data_length_reg <= cfg_data;
        end
    end

    // stage 1: clamp length, mask, place data bits
    hes_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .in_item     (cmd),
        .data_length (data_length_reg),
        .out_valid   (prep_valid),
        .out_item    (prep_item)
    );

    // stages 2 and 3: syndrome tree and result
    hes_synd u_synd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_item   (prep_item),
        .out_valid (done),
        .out_item  (result)
    );

endmodule

`default_nettype wire

// ===== rtl/hes_prep.sv =====
`default_nettype none

module hes_prep
    import hes_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire in_item_t          in_item,
    input  wire logic [LEN_W-1:0]  data_length,
    output logic                   out_valid,
    output prep_item_t             out_item
);

    logic                     valid_reg;
    prep_item_t               item_reg;
    prep_item_t               item_next;
    logic [LEN_W-1:0]         n_bits;
    logic [LEN_W-1:0]         len_bits;
    logic [MAX_DATA_BITS-1:0] data_mask;
    logic [MAX_CODE_BITS-1:0] code_mask;

    assign n_bits   = eff_data_bits(data_length);
    assign len_bits = code_length(n_bits);

    always_comb
    begin
        for (int i = 0; i < MAX_DATA_BITS; i++) begin
            data_mask[i] = (LEN_W'(i) < n_bits);
        end
        for (int i = 0; i < MAX_CODE_BITS; i++) begin
            code_mask[i] = (LEN_W'(i) < len_bits);
        end
    end

    always_comb
    begin
        item_next.opcode = in_item.opcode;
        unique case (in_item.opcode)
            OP_ENCODE: item_next.word = scatter(in_item.data_word & data_mask);
            OP_CHECK:  item_next.word = in_item.received_word & code_mask;
            default:   item_next.word = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/hes_synd.sv =====
`default_nettype none

module hes_synd
    import hes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire prep_item_t  in_item,
    output logic             out_valid,
    output out_item_t        out_item
);

    // Stage 2: partial syndromes over groups of positions
    logic                                 valid2_reg;
    prep_item_t                           item2_reg;
    logic [NUM_GROUPS-1:0][SYN_W-1:0]     part_reg;
    logic [NUM_GROUPS-1:0][SYN_W-1:0]     part_next;

    // Stage 3: result register
    logic                                 valid3_reg;
    out_item_t                            res_reg;
    out_item_t                            res_next;
    logic [SYN_W-1:0]                     syn;

    always_comb
    begin
        part_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            for (int j = 0; j < GROUP_BITS; j++) begin
                if (g * GROUP_BITS + j < MAX_CODE_BITS) begin
                    for (int k = 0; k < SYN_W; k++) begin
                        if ((((g * GROUP_BITS + j + 1) >> k) & 1) == 1) begin
                            part_next[g][k] = part_next[g][k]
                                ^ in_item.word[g * GROUP_BITS + j];
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        syn = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            syn = syn ^ part_reg[g];
        end
    end

    always_comb
    begin
        res_next = '0;
        unique case (item2_reg.opcode)
            OP_ENCODE:
            begin
                res_next.code_word = item2_reg.word;
                // parity for positions past the length is always zero
                for (int k = 0; k < SYN_W; k++) begin
                    res_next.code_word[(1 << k) - 1] = syn[k];
                end
            end
            OP_CHECK:
            begin
                res_next.error_position = syn;
                res_next.error_found    = |syn;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end else begin
            valid2_reg <= in_valid;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid) begin
            item2_reg <= in_item;
            part_reg  <= part_next;
        end
        if (valid2_reg) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid3_reg;
    assign out_item  = res_reg;

endmodule

`default_nettype wire
